@@ rtl/wgm_pkg.sv @@
// Package for the wildcard glob matcher: register indexes, item kinds,
// pattern character codes and fixed field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wgm_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int LEN_W       = 6;
  localparam int CHAR_W      = 8;
  localparam int PAT_WORDS   = 4;
  localparam int PAT_BITS    = PAT_WORDS * CFG_DATA_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LENGTH  = 3'd0,
    REG_PATTERN_BYTES_0 = 3'd1,
    REG_PATTERN_BYTES_1 = 3'd2,
    REG_PATTERN_BYTES_2 = 3'd3,
    REG_PATTERN_BYTES_3 = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_QMARK = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

endpackage

`default_nettype wire

@@ rtl/wgm_cfg_regs.sv @@
// Configuration register file of the glob matcher: pattern length and
// four words of pattern characters. Depends on wgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wgm_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [wgm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [wgm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic      [wgm_pkg::LEN_W-1:0]         pat_len,
  output logic      [wgm_pkg::PAT_BITS-1:0]      pat_chars
);

  logic [wgm_pkg::LEN_W-1:0]      len_r;
  logic [wgm_pkg::CFG_DATA_W-1:0] bytes0_r, bytes1_r, bytes2_r, bytes3_r;
  logic                           wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      bytes0_r <= '0;
      bytes1_r <= '0;
      bytes2_r <= '0;
      bytes3_r <= '0;
    end else if (wr) begin
      case (cfg_index)
        wgm_pkg::REG_PATTERN_LENGTH:  len_r    <= cfg_data[wgm_pkg::LEN_W-1:0];
        wgm_pkg::REG_PATTERN_BYTES_0: bytes0_r <= cfg_data;
        wgm_pkg::REG_PATTERN_BYTES_1: bytes1_r <= cfg_data;
        wgm_pkg::REG_PATTERN_BYTES_2: bytes2_r <= cfg_data;
        wgm_pkg::REG_PATTERN_BYTES_3: bytes3_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pat_len   = len_r;
  assign pat_chars = {bytes3_r, bytes2_r, bytes1_r, bytes0_r};

endmodule

`default_nettype wire

@@ rtl/wgm_pattern_decode.sv @@
// Pattern decode: effective length, in-use, star and '?' masks, position
// mask and final-position select. Depends on wgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wgm_pattern_decode #(
  parameter int PATTERN_MAX = 32
) (
  input  wire logic [wgm_pkg::LEN_W-1:0]    pat_len,
  input  wire logic [wgm_pkg::PAT_BITS-1:0] pat_chars,
  output logic      [PATTERN_MAX-1:0]       in_use,
  output logic      [PATTERN_MAX-1:0]       is_star,
  output logic      [PATTERN_MAX-1:0]       is_qmark,
  output logic      [PATTERN_MAX:0]         pos_mask,
  output logic      [PATTERN_MAX:0]         end_pos
);

  logic [wgm_pkg::LEN_W-1:0] lim;
  logic [PATTERN_MAX-1:0]    nz;

  assign lim = (pat_len > wgm_pkg::LEN_W'(PATTERN_MAX)) ?
               wgm_pkg::LEN_W'(PATTERN_MAX) : pat_len;

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      nz[i] = pat_chars[i*wgm_pkg::CHAR_W +: wgm_pkg::CHAR_W] != wgm_pkg::CH_NUL;
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      in_use[i] = wgm_pkg::LEN_W'(i) < lim;
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (j <= i) begin
          in_use[i] = in_use[i] & nz[j];
        end
      end
      is_star[i]  = in_use[i] &&
                    (pat_chars[i*wgm_pkg::CHAR_W +: wgm_pkg::CHAR_W] == wgm_pkg::CH_STAR);
      is_qmark[i] = in_use[i] &&
                    (pat_chars[i*wgm_pkg::CHAR_W +: wgm_pkg::CHAR_W] == wgm_pkg::CH_QMARK);
    end
  end

  assign pos_mask = {in_use, 1'b1};
  assign end_pos  = pos_mask & ~{1'b0, in_use};

endmodule

`default_nettype wire

@@ rtl/wgm_star_close.sv @@
// Forward closure of an active set through star positions, built as a
// log-depth prefix network, then masked to the pattern. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wgm_star_close #(
  parameter int PATTERN_MAX = 32
) (
  input  wire logic [PATTERN_MAX:0]   set_in,
  input  wire logic [PATTERN_MAX-1:0] is_star,
  input  wire logic [PATTERN_MAX:0]   pos_mask,
  output logic      [PATTERN_MAX:0]   set_out
);

  localparam int LVL = $clog2(PATTERN_MAX + 1);

  logic [PATTERN_MAX:0] g [LVL+1];
  logic [PATTERN_MAX:0] p [LVL+1];

  always_comb begin
    g[0] = set_in;
    p[0] = {is_star, 1'b0};
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i <= PATTERN_MAX; i++) begin
        if (i >= (1 << l)) begin
          g[l+1][i] = g[l][i] | (p[l][i] & g[l][i-(1<<l)]);
          p[l+1][i] = p[l][i] & p[l][i-(1<<l)];
        end else begin
          g[l+1][i] = g[l][i];
          p[l+1][i] = 1'b0;
        end
      end
    end
    set_out = g[LVL] & pos_mask & {1'b1, p[LVL][PATTERN_MAX:1] | ~p[LVL][PATTERN_MAX:1]};
  end

endmodule

`default_nettype wire

@@ rtl/wildcard_glob_matcher_core.sv @@
// Top level of the wildcard glob matcher: input word register, one-pass
// active-set update and result register. Depends on wgm_pkg, wgm_cfg_regs,
// wgm_pattern_decode and wgm_star_close.
//
//   channel  dir  handshake            payload
//   in       in   in_tvalid/tready     tdata: char_byte[7:0]; tuser: kind
//   out      out  out_tvalid/tready    tdata: matched[0], zeros [7:1]
//   cfg      in   cfg_valid/ready      cfg_index[2:0], cfg_data[63:0]
//
// One word per cycle sustained while no end word waits; each word is held in the
// input register, and an end-of-string word loads the result register as it leaves.
// The update is two star closures and one match step between registers.
// rst_n is synchronous: clears the pattern, empties both registers and
// leaves only the start position active. An end word waits in the input
// register while an earlier result is not taken; character words never wait.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_glob_matcher_core #(
  parameter int PATTERN_MAX = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,   // char_byte[7:0]
  input  wire logic                            in_tuser,   // kind[0]
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [7:0]                      out_tdata,  // matched[0], zero fill [7:1]
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [wgm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [wgm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [wgm_pkg::LEN_W-1:0]    pat_len;
  logic [wgm_pkg::PAT_BITS-1:0] pat_chars;
  logic [PATTERN_MAX-1:0]       in_use, is_star, is_qmark, char_eq, adv;
  logic [PATTERN_MAX:0]         pos_mask, end_pos;
  logic [PATTERN_MAX:0]         active_r, active_nxt, cur, step_set, close_in, closed;

  logic                         s1_valid_r, s1_valid_nxt;
  wgm_pkg::kind_t               s1_kind_r;
  logic [wgm_pkg::CHAR_W-1:0]   s1_char_r;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_matched_r, out_matched_nxt;
  logic                         s1_fire, out_free, in_fire, is_end;

  wgm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pat_len   (pat_len),
    .pat_chars (pat_chars)
  );

  wgm_pattern_decode #(.PATTERN_MAX(PATTERN_MAX)) u_dec (
    .pat_len   (pat_len),
    .pat_chars (pat_chars),
    .in_use    (in_use),
    .is_star   (is_star),
    .is_qmark  (is_qmark),
    .pos_mask  (pos_mask),
    .end_pos   (end_pos)
  );

  wgm_star_close #(.PATTERN_MAX(PATTERN_MAX)) u_close_cur (
    .set_in   (active_r),
    .is_star  (is_star),
    .pos_mask (pos_mask),
    .set_out  (cur)
  );

  wgm_star_close #(.PATTERN_MAX(PATTERN_MAX)) u_close_nxt (
    .set_in   (close_in),
    .is_star  (is_star),
    .pos_mask (pos_mask),
    .set_out  (closed)
  );

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      char_eq[i] = pat_chars[i*wgm_pkg::CHAR_W +: wgm_pkg::CHAR_W] == s1_char_r;
    end
  end

  assign adv      = cur[PATTERN_MAX-1:0] & in_use & ~is_star & (is_qmark | char_eq);
  assign step_set = {1'b0, cur[PATTERN_MAX-1:0] & is_star} | {adv, 1'b0};
  assign is_end   = s1_kind_r == wgm_pkg::KIND_END;
  assign close_in = is_end ? {{PATTERN_MAX{1'b0}}, 1'b1} : step_set;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!is_end || out_free);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt    = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    active_nxt      = s1_fire ? closed : active_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_matched_nxt = out_matched_r;
    if (s1_fire && is_end) begin
      out_valid_nxt   = 1'b1;
      out_matched_nxt = |(cur & end_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      out_matched_r <= 1'b0;
      active_r      <= {{PATTERN_MAX{1'b0}}, 1'b1};
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      out_matched_r <= out_matched_nxt;
      active_r      <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r <= wgm_pkg::kind_t'(in_tuser);
      s1_char_r <= in_tdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_matched_r};

  a_end_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && is_end) |=> out_valid_r)
    else $error("end word did not load the result register");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && is_end) |=> active_r[0])
    else $error("start position not active after end of string");

  a_char_keeps_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !is_end) |=> $stable(out_matched_r))
    else $error("character word changed the result");

  a_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && is_end && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while end word is stalled");

endmodule

`default_nettype wire

@@ bench/tb_wildcard_glob_matcher_core.sv @@
// Self-checking bench for wildcard_glob_matcher_core: directed table, then random
// patterns and strings checked against an in-bench glob predictor.
// Depends on wgm_pkg and the wildcard_glob_matcher_core RTL.
`timescale 1ns / 1ps

module tb_wildcard_glob_matcher_core;

  localparam int PAT_MAX       = 32;
  localparam int RANDOM_WORDS  = 700;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [wgm_pkg::CFG_INDEX_W-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [wgm_pkg::CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam logic [PAT_MAX:0] START_SET = {{PAT_MAX{1'b0}}, 1'b1};

  localparam wgm_pkg::kind_t K_CHAR = wgm_pkg::KIND_CHAR;
  localparam wgm_pkg::kind_t K_END  = wgm_pkg::KIND_END;
  localparam logic [wgm_pkg::CFG_INDEX_W-1:0] R_LEN = wgm_pkg::REG_PATTERN_LENGTH;
  localparam logic [wgm_pkg::CFG_INDEX_W-1:0] R_B0  = wgm_pkg::REG_PATTERN_BYTES_0;
  localparam logic [wgm_pkg::CFG_INDEX_W-1:0] R_B1  = wgm_pkg::REG_PATTERN_BYTES_1;
  localparam logic [wgm_pkg::CFG_INDEX_W-1:0] R_B2  = wgm_pkg::REG_PATTERN_BYTES_2;
  localparam logic [wgm_pkg::CFG_INDEX_W-1:0] R_B3  = wgm_pkg::REG_PATTERN_BYTES_3;

  typedef enum logic {
    ROW_WORD = 1'b0,
    ROW_REG  = 1'b1
  } row_op_t;

  typedef struct packed {
    row_op_t                             op;
    logic [wgm_pkg::CFG_INDEX_W-1:0]     idx;
    logic [wgm_pkg::CFG_DATA_W-1:0]      val;
    wgm_pkg::kind_t                      kind;
    logic [wgm_pkg::CHAR_W-1:0]          ch;
    logic                                chk;
    logic                                want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [0:27] = '{
    '{ROW_WORD, 3'd0, 64'd0, K_END, 8'h00, 1'b1, 1'b1},
    '{ROW_WORD, 3'd0, 64'd0, K_CHAR, 8'h61, 1'b0, 1'b0},
    '{ROW_WORD, 3'd0, 64'd0, K_END, 8'h00, 1'b1, 1'b0},
    '{ROW_REG, REG_SPARE_5, {64{1'b1}}, K_CHAR, 8'h00, 1'b0, 1'b0},
    '{ROW_REG, REG_SPARE_7, {64{1'b1}}, K_CHAR, 8'h00, 1'b0, 1'b0},
    '{ROW_WORD, 3'd0, 64'd0, K_END, 8'h00, 1'b1, 1'b1},
    '{ROW_REG, R_LEN, 64'd63, K_CHAR, 8'h00, 1'b0, 1'b0},
    '{ROW_REG, R_B0, 64'h0000_0063_3F2A_6261, K_CHAR, 8'h00, 1'b0, 1'b0},
    '{ROW_REG, R_B1, {64{1'b1}}, K_CHAR, 8'h00, 1'b0, 1'b0},
    '{ROW_REG, R_B2, {64{1'b1}}, K_CHAR, 8'h00, 1'b0, 1'b0},
    '{ROW_REG, R_B3, {64{1'b1}}, K_CHAR, 8'h00, 1'b0, 1'b0},
    '{ROW_WORD, 3'd0, 64'd0, K_CHAR, 8'h61, 1'b0, 1'b0},
    '{ROW_WORD, 3'd0, 64'd0, K_CHAR, 8'h62, 1'b0, 1'b0},
    '{ROW_WORD, 3'd0, 64'd0, K_CHAR, wgm_pkg::CH_STAR, 1'b0, 1'b0},
    '{ROW_WORD, 3'd0, 64'd0, K_CHAR, 8'h63, 1'b0, 1'b0},
    '{ROW_WORD, 3'd0, 64'd0, K_END, 8'hFF, 1'b0, 1'b0},
    '{ROW_WORD, 3'd0, 64'd0, K_CHAR, wgm_pkg::CH_NUL, 1'b0, 1'b0},
    '{ROW_WORD, 3'd0, 64'd0, K_END, 8'h00, 1'b0, 1'b0},
    '{ROW_REG, R_B0, 64'h2A2A_2A2A_2A2A_2A2A, K_CHAR, 8'h00, 1'b0, 1'b0},
    '{ROW_WORD, 3'd0, 64'd0, K_CHAR, 8'hFF, 1'b0, 1'b0},
    '{ROW_WORD, 3'd0, 64'd0, K_CHAR, wgm_pkg::CH_QMARK, 1'b0, 1'b0},
    '{ROW_WORD, 3'd0, 64'd0, K_END, 8'h00, 1'b0, 1'b0},
    '{ROW_WORD, 3'd0, 64'd0, K_CHAR, 8'h61, 1'b0, 1'b0},
    '{ROW_REG, R_LEN, 64'd0, K_CHAR, 8'h00, 1'b0, 1'b0},
    '{ROW_WORD, 3'd0, 64'd0, K_END, 8'h00, 1'b0, 1'b0},
    '{ROW_REG, R_LEN, 64'd32, K_CHAR, 8'h00, 1'b0, 1'b0},
    '{ROW_WORD, 3'd0, 64'd0, K_CHAR, 8'hFF, 1'b0, 1'b0},
    '{ROW_WORD, 3'd0, 64'd0, K_END, 8'hFF, 1'b0, 1'b0}
  };

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [7:0]                      in_tdata;   // char_byte[7:0]
  logic                            in_tuser;   // kind[0]
  logic                            out_tvalid;
  logic                            out_tready;
  logic [7:0]                      out_tdata;  // matched[0], zero fill [7:1]
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [wgm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [wgm_pkg::CFG_DATA_W-1:0]  cfg_data;

  logic [wgm_pkg::LEN_W-1:0]    pat_len;
  logic [wgm_pkg::PAT_BITS-1:0] pat_flat;
  logic [PAT_MAX:0]             active_set;
  logic                         pending_match[$];

  int   errors = 0;
  int   stall_cycles = 0;
  int   stall_left = 0;
  int   words_sent = 0;
  bit   out_taken = 0;
  bit   hold_req = 0;
  bit   no_idle = 0;
  bit   fixed_valid = 0;
  logic fixed_value = 1'b0;

  logic [wgm_pkg::CHAR_W-1:0] gen_chars [PAT_MAX];
  logic [wgm_pkg::LEN_W-1:0]  gen_len;

  wildcard_glob_matcher_core #(
    .PATTERN_MAX(PAT_MAX)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [wgm_pkg::CHAR_W-1:0] pat_at(int i);
    return pat_flat[i*8 +: 8];
  endfunction

  function automatic int live_len();
    int lim;
    lim = (pat_len > PAT_MAX) ? PAT_MAX : int'(pat_len);
    for (int i = 0; i < lim; i++) begin
      if (pat_at(i) == wgm_pkg::CH_NUL) return i;
    end
    return lim;
  endfunction

  function automatic logic [PAT_MAX:0] star_fill(logic [PAT_MAX:0] s, int n);
    for (int i = 0; i < n; i++) begin
      if (s[i] && pat_at(i) == wgm_pkg::CH_STAR) s[i+1] = 1'b1;
    end
    for (int i = 0; i <= PAT_MAX; i++) begin
      if (i > n) s[i] = 1'b0;
    end
    return s;
  endfunction

  function automatic int idle_gap();
    return no_idle ? 0 : int'($urandom_range(0, 16));
  endfunction

  function automatic logic [wgm_pkg::CHAR_W-1:0] str_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return 8'(8'h61 + $urandom_range(0, 3));
    if (r == 14) return wgm_pkg::CH_STAR;
    if (r == 15) return wgm_pkg::CH_QMARK;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [wgm_pkg::CHAR_W-1:0] pat_pick();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return 8'(8'h61 + $urandom_range(0, 2));
    if (r < 12) return wgm_pkg::CH_STAR;
    if (r < 16) return wgm_pkg::CH_QMARK;
    if (r == 16) return wgm_pkg::CH_NUL;
    return 8'($urandom_range(0, 255));
  endfunction

  // Predict on every accepted word and register write; check every result.
  always @(posedge clk) begin : monitor
    int n;
    logic [PAT_MAX:0] cur;
    logic [PAT_MAX:0] nxt;
    logic [wgm_pkg::CHAR_W-1:0] p;
    logic want;
    bit busy;
    if (!rst_n) begin
      pat_len = '0;
      pat_flat = '0;
      active_set = START_SET;
      pending_match.delete();
      stall_cycles = 0;
    end else begin
      busy = 1'b0;
      if (out_tvalid && out_tready) begin
        busy = 1'b1;
        out_taken = 1'b1;
        if (pending_match.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time, out_tdata);
          errors++;
        end else begin
          want = pending_match.pop_front();
          if (out_tdata !== {7'd0, want}) begin
            $display("%0t: matched mismatch, expected %0d, actual %0d",
                     $time, {7'd0, want}, out_tdata);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        busy = 1'b1;
        n = live_len();
        cur = star_fill(active_set, n);
        if (in_tuser == wgm_pkg::KIND_END) begin
          pending_match.push_back(fixed_valid ? fixed_value : cur[n]);
          fixed_valid = 1'b0;
          active_set = star_fill(START_SET, n);
        end else begin
          nxt = '0;
          for (int i = 0; i < n; i++) begin
            if (cur[i]) begin
              p = pat_at(i);
              if (p == wgm_pkg::CH_STAR) nxt[i] = 1'b1;
              else if (p == wgm_pkg::CH_QMARK || p == in_tdata) nxt[i+1] = 1'b1;
            end
          end
          active_set = star_fill(nxt, n);
        end
      end
      if (cfg_valid && cfg_ready) begin
        busy = 1'b1;
        case (cfg_index)
          R_LEN: pat_len = cfg_data[wgm_pkg::LEN_W-1:0];
          R_B0:  pat_flat[63:0] = cfg_data;
          R_B1:  pat_flat[127:64] = cfg_data;
          R_B2:  pat_flat[191:128] = cfg_data;
          R_B3:  pat_flat[255:192] = cfg_data;
          default: ;
        endcase
      end
      stall_cycles = busy ? 0 : stall_cycles + 1;
    end
  end

  // Result side: random stalls after each taken result, plus one long hold on request.
  initial begin : receiver
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (out_taken) begin
        out_taken = 1'b0;
        stall_left = idle_gap();
      end
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("wildcard_glob_matcher_core verification failed");
    $finish;
  end

  task automatic send_word(wgm_pkg::kind_t k, logic [wgm_pkg::CHAR_W-1:0] c);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser = k;
    in_tdata = c;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    words_sent++;
  endtask

  // Drop valid, drain all results, then let the pipeline settle.
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending_match.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [wgm_pkg::CFG_INDEX_W-1:0] idx,
                           logic [wgm_pkg::CFG_DATA_W-1:0] d);
    cfg_index = idx;
    cfg_data = d;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic new_pattern();
    logic [wgm_pkg::CFG_DATA_W-1:0] w;
    if ($urandom_range(0, 7) == 0) gen_len = 6'($urandom_range(25, 63));
    else gen_len = 6'($urandom_range(0, 10));
    for (int i = 0; i < PAT_MAX; i++) begin
      gen_chars[i] = (i < gen_len) ? pat_pick() : 8'($urandom_range(0, 255));
    end
    w = {$urandom, $urandom};
    w[wgm_pkg::LEN_W-1:0] = gen_len;
    write_reg(R_LEN, w);
    for (int r = 0; r < wgm_pkg::PAT_WORDS; r++) begin
      for (int b = 0; b < 8; b++) w[b*8 +: 8] = gen_chars[r*8 + b];
      write_reg(3'(int'(R_B0) + r), w);
    end
    if ($urandom_range(0, 4) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_5 : REG_SPARE_7, {$urandom, $urandom});
  endtask

  // Mostly strings shaped on the pattern, else free noise.
  task automatic send_string(bit finish);
    int lim;
    int eff;
    lim = (gen_len > PAT_MAX) ? PAT_MAX : int'(gen_len);
    for (eff = 0; eff < lim && gen_chars[eff] != wgm_pkg::CH_NUL; eff++) ;
    if ($urandom_range(0, 4) != 0) begin
      for (int i = 0; i < eff; i++) begin
        if (gen_chars[i] == wgm_pkg::CH_STAR) begin
          repeat ($urandom_range(0, 3)) send_word(K_CHAR, str_char());
        end else if (gen_chars[i] == wgm_pkg::CH_QMARK) begin
          send_word(K_CHAR, str_char());
        end else begin
          send_word(K_CHAR, ($urandom_range(0, 19) == 0) ? str_char() : gen_chars[i]);
        end
      end
    end else begin
      repeat ($urandom_range(0, 10)) send_word(K_CHAR, str_char());
    end
    if (finish) send_word(K_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int phase;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = K_CHAR;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gen_len = '0;
    for (int i = 0; i < PAT_MAX; i++) gen_chars[i] = wgm_pkg::CH_NUL;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].op == ROW_REG) begin
        wait_idle();
        write_reg(DIRECTED[i].idx, DIRECTED[i].val);
      end else begin
        if (DIRECTED[i].chk) begin
          fixed_value = DIRECTED[i].want;
          fixed_valid = 1'b1;
        end
        send_word(DIRECTED[i].kind, DIRECTED[i].ch);
      end
    end

    words_sent = 0;
    phase = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (phase > 0 && $urandom_range(0, 4) == 0) send_string(1'b0);
      wait_idle();
      no_idle = ($urandom_range(0, 3) == 0);
      new_pattern();
      if (phase == 2) begin
        no_idle = 1'b1;
        hold_req = 1'b1;
        repeat (8) send_word(K_END, 8'($urandom_range(0, 255)));
        no_idle = 1'b0;
        wait_idle();
      end
      repeat ($urandom_range(6, 16)) begin
        if (words_sent < RANDOM_WORDS) send_string(1'b1);
      end
      phase++;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("wildcard_glob_matcher_core verification clean");
    end else begin
      $display("wildcard_glob_matcher_core verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/wgm_pkg.sv
rtl/wgm_cfg_regs.sv
rtl/wgm_pattern_decode.sv
rtl/wgm_star_close.sv
rtl/wildcard_glob_matcher_core.sv
bench/tb_wildcard_glob_matcher_core.sv
